// File: sv/dsbf_pkg.sv
// ----------------------------------------------------------------------------
// dsbf_pkg
// Shared types and constants for the stored-block framer.
// ----------------------------------------------------------------------------
package dsbf_pkg;

  localparam int MAX_BLOCK   = 65535;
  localparam int BLOCK_MOD   = MAX_BLOCK % 65536;
  localparam int BLOCK_LIMIT = (BLOCK_MOD == 0) ? 1 : BLOCK_MOD;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  // output positions within one job
  typedef enum logic [2:0] {
    POS_BFINAL = 3'd0,
    POS_LEN_LO = 3'd1,
    POS_LEN_HI = 3'd2,
    POS_NLN_LO = 3'd3,
    POS_NLN_HI = 3'd4,
    POS_DATA   = 3'd5
  } pos_e;

  localparam logic [7:0] BFINAL_SET = 8'h01;
  localparam logic [7:0] BFINAL_CLR = 8'h00;

  typedef struct packed {
    logic        hdr;
    logic        final_blk;
    logic [15:0] len;
    logic        has_data;
    logic [7:0]  data;
    logic        done;
    logic        err;
  } job_t;

endpackage

// File: sv/dsbf_if.sv
// ----------------------------------------------------------------------------
// dsbf_if
// Channel interfaces: input items, result bytes and configuration writes.
// ----------------------------------------------------------------------------
interface dsbf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface dsbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;
  logic       error_flag;
  modport source (output valid, output out_byte, output run_last, output stream_done,
                  output error_flag, input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  input error_flag, output ready);
endinterface

interface dsbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_length;
  modport source (output valid, output total_length, input ready);
  modport sink   (input valid, input total_length, output ready);
endinterface

// File: sv/dsbf_front.sv
// ----------------------------------------------------------------------------
// dsbf_front
// Takes input items, tracks stream and block counts, and issues framing jobs.
// ----------------------------------------------------------------------------
module dsbf_front
  import dsbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dsbf_in_if.sink    in_i,
  dsbf_cfg_if.sink   cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam logic [15:0] LIM16 = 16'(BLOCK_LIMIT);
  localparam logic [31:0] LIM32 = 32'(BLOCK_LIMIT);

  logic [31:0] total_q;
  logic [31:0] rem_q, rem_d;
  logic [15:0] blk_q, blk_d;
  logic        active_q, active_d;
  logic        acc;
  logic [15:0] amount, base;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign acc         = in_i.valid && !full_i;

  always_comb begin
    rem_d    = rem_q;
    blk_d    = blk_q;
    active_d = active_q;
    push_o   = 1'b0;
    job_o    = '0;
    amount   = (rem_q < LIM32) ? rem_q[15:0] : LIM16;
    base     = (blk_q == 16'd0) ? amount : blk_q;
    if (acc) begin
      if (in_i.command == CMD_START) begin
        rem_d = total_q;
        blk_d = 16'd0;
        if (total_q == 32'd0) begin
          active_d        = 1'b0;
          push_o          = 1'b1;
          job_o.hdr       = 1'b1;
          job_o.final_blk = 1'b1;
          job_o.done      = 1'b1;
        end else begin
          active_d = 1'b1;
        end
      end else if (!active_q || rem_q == 32'd0) begin
        push_o         = 1'b1;
        job_o.has_data = 1'b1;
        job_o.err      = 1'b1;
      end else begin
        push_o          = 1'b1;
        job_o.hdr       = (blk_q == 16'd0);
        job_o.final_blk = (rem_q <= LIM32);
        job_o.len       = amount;
        job_o.has_data  = 1'b1;
        job_o.data      = in_i.data_byte;
        rem_d           = rem_q - 32'd1;
        blk_d           = base - 16'd1;
        if (rem_q == 32'd1) begin
          job_o.done = 1'b1;
          active_d   = 1'b0;
          blk_d      = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      rem_q    <= '0;
      blk_q    <= '0;
      active_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        total_q <= cfg_i.total_length;
      end
      rem_q    <= rem_d;
      blk_q    <= blk_d;
      active_q <= active_d;
    end
  end

endmodule

// File: sv/dsbf_queue.sv
// ----------------------------------------------------------------------------
// dsbf_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module dsbf_queue
  import dsbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/dsbf_back.sv
// ----------------------------------------------------------------------------
// dsbf_back
// Expands each job into header and data bytes through an output register.
// ----------------------------------------------------------------------------
module dsbf_back
  import dsbf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      head_i,
  output logic      pop_o,
  dsbf_out_if.source out_o
);

  logic [2:0] cnt_q, cnt_d;
  logic [2:0] pos;
  logic       last;
  logic       adv;
  logic [7:0] byte_d;
  logic       vld_q;
  logic [7:0] byte_q;
  logic       last_q, done_q, err_q;

  assign pos  = head_i.hdr ? cnt_q : POS_DATA;
  assign last = head_i.has_data ? (pos == POS_DATA) : (pos == POS_NLN_HI);
  assign adv  = !empty_i && (!vld_q || out_o.ready);
  assign pop_o = adv && last;

  always_comb begin
    unique case (pos)
      POS_BFINAL: byte_d = head_i.final_blk ? BFINAL_SET : BFINAL_CLR;
      POS_LEN_LO: byte_d = head_i.len[7:0];
      POS_LEN_HI: byte_d = head_i.len[15:8];
      POS_NLN_LO: byte_d = ~head_i.len[7:0];
      POS_NLN_HI: byte_d = ~head_i.len[15:8];
      default:    byte_d = head_i.data;
    endcase
    cnt_d = cnt_q;
    if (adv) begin
      cnt_d = last ? 3'd0 : cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (adv) begin
        vld_q <= 1'b1;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      last_q <= last;
      done_q <= last && head_i.done;
      err_q  <= head_i.err;
    end
  end

  assign out_o.valid       = vld_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.run_last    = last_q;
  assign out_o.stream_done = done_q;
  assign out_o.error_flag  = err_q;

endmodule

// File: sv/deflate_stored_block_framer.sv
// ----------------------------------------------------------------------------
// deflate_stored_block_framer
// Frames a byte stream of declared length into stored deflate blocks.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer when
//  in_i     in   command, data_byte                        valid && ready
//  cfg_i    in   total_length                              valid (ready tied high)
//  out_o    out  out_byte, run_last, stream_done, error_flag  valid && ready
//
//  the front takes one item a cycle while the job queue has room
//  the back sends one byte a cycle: a byte item gives one byte, or six when
//  it opens a block; an empty stream gives five; the output port sets the pace
//  reset clears counts, stream state, queue pointers and the output valid
//  a stalled output fills the four-entry job queue, then in_i.ready falls
// ----------------------------------------------------------------------------
module deflate_stored_block_framer
  import dsbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dsbf_in_if.sink     in_i,
  dsbf_cfg_if.sink    cfg_i,
  dsbf_out_if.source  out_o
);

  logic push, full, pop, empty;
  job_t push_job, head_job;

  dsbf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  dsbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_job)
  );

  dsbf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // no job dropped at a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("job pushed into full queue");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && empty))
    else $error("job popped from empty queue");

  // an error result is a single closing byte that ends no stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_flag |-> out_o.run_last && !out_o.stream_done)
    else $error("error result malformed");

  // stream end only on the last byte of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.stream_done |-> out_o.run_last)
    else $error("stream end not on last byte");

endmodule
